@@ rtl/core/gcis_pkg.sv @@
// Shared types and constants of the grid CDF inverse sampler.
package gcis_pkg;

    // Field widths
    localparam int unsigned WEIGHT_W       = 16;
    localparam int unsigned FRACTION_W     = 16;
    localparam int unsigned TOTAL_W        = 28;
    localparam int unsigned DIM_W          = 7;
    localparam int unsigned COORD_W        = 6;
    localparam int unsigned CELL_W         = 13;
    localparam int unsigned DIV_CNT_W      = $clog2(CELL_W + 1);
    localparam int unsigned GRID_MAX_DIM   = 64;
    localparam int unsigned GRID_MAX_CELLS = GRID_MAX_DIM * GRID_MAX_DIM;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_ROWS    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_COLUMNS = 1'b1;

    // Command modes
    localparam logic [1:0] MODE_CLEAR  = 2'd0;
    localparam logic [1:0] MODE_LOAD   = 2'd1;
    localparam logic [1:0] MODE_SAMPLE = 2'd2;

    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_DONE  = 2'd1,
        STATUS_EMPTY = 2'd2,
        STATUS_FULL  = 2'd3
    } t_status;

    typedef struct packed {
        logic [1:0]                 mode;
        logic signed [WEIGHT_W-1:0] cell_weight;
        logic [FRACTION_W-1:0]      sample_fraction;
    } t_cmd_beat;

    typedef struct packed {
        logic [COORD_W-1:0] row_index;
        logic [COORD_W-1:0] column_index;
        t_status            status;
    } t_result_beat;

    // One table entry: cumulative weight and the cell it ends on
    typedef struct packed {
        logic [TOTAL_W-1:0] cum;
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
    } t_cdf_entry;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_DIV,
        ST_COMMIT,
        ST_PROBE_RD,
        ST_PROBE_CMP,
        ST_FINAL
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic    capture;
        logic    clear;
        logic    skip;
        logic    div_start;
        logic    div_step;
        logic    commit;
        logic    search_init;
        logic    probe_rd;
        logic    probe_upd;
        logic    emit;
        t_status emit_status;
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic [1:0] mode;
        logic       grid_full;
        logic       weight_pos;
        logic       table_empty;
        logic       div_done;
        logic       search_done;
    } t_dp_sts;

endpackage

@@ rtl/core/gcis_datapath.sv @@
// Datapath: config registers, cumulative table, raster divider, scaling and search.
module gcis_datapath #(
    parameter int unsigned MAX_CELLS = 4096
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [gcis_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [gcis_pkg::DIM_W-1:0]           i_cfg_data,
    input  gcis_pkg::t_cmd_beat                  i_cmd,
    input  gcis_pkg::t_dp_cmd                    i_dp_cmd,
    output gcis_pkg::t_dp_sts                    o_sts,
    output logic                                 o_done,
    output gcis_pkg::t_result_beat               o_result
);
    import gcis_pkg::*;

    localparam int unsigned CAP_LIMIT =
        (MAX_CELLS < GRID_MAX_CELLS) ? MAX_CELLS : GRID_MAX_CELLS;
    localparam int unsigned IDX_W = (CAP_LIMIT > 1) ? $clog2(CAP_LIMIT) : 1;
    localparam int unsigned CNT_W = $clog2(CAP_LIMIT + 1);
    localparam int unsigned PROD_W = 2 * DIM_W;
    localparam logic [PROD_W-1:0] CAP_LIM = PROD_W'(CAP_LIMIT);
    localparam logic [DIM_W-1:0] DIM_ONE = DIM_W'(1);
    localparam logic [DIM_W-1:0] DIM_MAX = DIM_W'(GRID_MAX_DIM);

    // Control state
    logic [DIM_W-1:0]     r_grid_rows;
    logic [DIM_W-1:0]     r_grid_cols;
    logic [CNT_W-1:0]     r_entry_count;
    logic [TOTAL_W-1:0]   r_total;
    logic [CELL_W-1:0]    r_next_cell;
    logic [DIV_CNT_W-1:0] r_div_cnt;
    logic                 r_done;

    // Payload
    t_cmd_beat          r_cmd;
    logic [CELL_W-1:0]  r_quo;
    logic [DIM_W-1:0]   r_rem;
    logic [TOTAL_W-1:0] r_target;
    logic [IDX_W-1:0]   r_lo;
    logic [IDX_W-1:0]   r_hi;
    t_cdf_entry         r_rd_data;
    t_result_beat       r_result;
    t_cdf_entry         r_mem [CAP_LIMIT];

    logic [DIM_W-1:0]               w_rows_c;
    logic [DIM_W-1:0]               w_cols_c;
    logic [PROD_W-1:0]              w_prod;
    logic [PROD_W-1:0]              w_cap;
    logic                           w_weight_pos;
    logic [DIM_W:0]                 w_trial;
    logic [DIM_W:0]                 w_trial_diff;
    logic                           w_trial_ge;
    logic [TOTAL_W:0]               w_sum;
    logic [TOTAL_W-1:0]             w_sum_sat;
    logic [FRACTION_W+TOTAL_W-1:0]  w_product;
    logic [IDX_W:0]                 w_mid_sum;
    logic [IDX_W-1:0]               w_mid;
    logic [CNT_W-1:0]               w_last;
    t_cdf_entry                     w_new_entry;

    // Clamped grid dimensions and capacity
    always_comb begin
        if (r_grid_rows == '0) begin
            w_rows_c = DIM_ONE;
        end else if (r_grid_rows > DIM_MAX) begin
            w_rows_c = DIM_MAX;
        end else begin
            w_rows_c = r_grid_rows;
        end
        if (r_grid_cols == '0) begin
            w_cols_c = DIM_ONE;
        end else if (r_grid_cols > DIM_MAX) begin
            w_cols_c = DIM_MAX;
        end else begin
            w_cols_c = r_grid_cols;
        end
    end

    assign w_prod = w_rows_c * w_cols_c;
    assign w_cap  = (w_prod > CAP_LIM) ? CAP_LIM : w_prod;

    assign w_weight_pos = !r_cmd.cell_weight[WEIGHT_W-1] && (r_cmd.cell_weight != '0);

    // One restoring division step: raster position by column count
    assign w_trial      = {r_rem, r_quo[CELL_W-1]};
    assign w_trial_ge   = w_trial >= {1'b0, w_cols_c};
    assign w_trial_diff = w_trial - {1'b0, w_cols_c};

    // Saturating running total
    assign w_sum     = {1'b0, r_total} + (TOTAL_W + 1)'(unsigned'(r_cmd.cell_weight));
    assign w_sum_sat = w_sum[TOTAL_W] ? '1 : w_sum[TOTAL_W-1:0];

    // Scaled search target: fraction times total, fraction bits dropped
    assign w_product = r_cmd.sample_fraction * r_total;

    assign w_mid_sum = {1'b0, r_lo} + {1'b0, r_hi};
    assign w_mid     = w_mid_sum[IDX_W:1];
    assign w_last    = r_entry_count - CNT_W'(1);

    assign w_new_entry.cum = w_sum_sat;
    assign w_new_entry.row = r_quo[COORD_W-1:0];
    assign w_new_entry.col = r_rem[COORD_W-1:0];

    // Status toward the controller
    assign o_sts.mode        = r_cmd.mode;
    assign o_sts.grid_full   = PROD_W'(r_next_cell) >= w_cap;
    assign o_sts.weight_pos  = w_weight_pos;
    assign o_sts.table_empty = (r_entry_count == '0);
    assign o_sts.div_done    = (r_div_cnt == '0);
    assign o_sts.search_done = (r_lo == r_hi);

    // Configuration and table bookkeeping
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_rows   <= DIM_MAX;
            r_grid_cols   <= DIM_MAX;
            r_entry_count <= '0;
            r_total       <= '0;
            r_next_cell   <= '0;
            r_div_cnt     <= '0;
            r_done        <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_GRID_ROWS:    r_grid_rows <= i_cfg_data;
                    CFG_GRID_COLUMNS: r_grid_cols <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_dp_cmd.clear) begin
                r_entry_count <= '0;
                r_total       <= '0;
                r_next_cell   <= '0;
            end
            if (i_dp_cmd.skip) begin
                r_next_cell <= r_next_cell + CELL_W'(1);
            end
            if (i_dp_cmd.commit) begin
                r_total       <= w_sum_sat;
                r_entry_count <= r_entry_count + CNT_W'(1);
                r_next_cell   <= r_next_cell + CELL_W'(1);
            end
            if (i_dp_cmd.div_start) begin
                r_div_cnt <= DIV_CNT_W'(CELL_W);
            end else if (i_dp_cmd.div_step) begin
                r_div_cnt <= r_div_cnt - DIV_CNT_W'(1);
            end
            r_done <= i_dp_cmd.emit;
        end
    end

    // Command capture, divider, search registers and result
    always_ff @(posedge i_clk) begin
        if (i_dp_cmd.capture) begin
            r_cmd <= i_cmd;
        end
        if (i_dp_cmd.div_start) begin
            r_quo <= r_next_cell;
            r_rem <= '0;
        end else if (i_dp_cmd.div_step) begin
            r_quo <= {r_quo[CELL_W-2:0], w_trial_ge};
            r_rem <= w_trial_ge ? w_trial_diff[DIM_W-1:0] : w_trial[DIM_W-1:0];
        end
        if (i_dp_cmd.search_init) begin
            r_target <= w_product[FRACTION_W +: TOTAL_W];
            r_lo     <= '0;
            r_hi     <= w_last[IDX_W-1:0];
        end else if (i_dp_cmd.probe_upd) begin
            if (r_rd_data.cum > r_target) begin
                r_hi <= w_mid;
            end else begin
                r_lo <= w_mid + IDX_W'(1);
            end
        end
        if (i_dp_cmd.emit) begin
            r_result.status <= i_dp_cmd.emit_status;
            if (i_dp_cmd.emit_status == STATUS_OK) begin
                r_result.row_index    <= r_rd_data.row;
                r_result.column_index <= r_rd_data.col;
            end else begin
                r_result.row_index    <= '0;
                r_result.column_index <= '0;
            end
        end
    end

    // Cumulative table: one write port, registered read at the midpoint
    always_ff @(posedge i_clk) begin
        if (i_dp_cmd.commit) begin
            r_mem[r_entry_count[IDX_W-1:0]] <= w_new_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_dp_cmd.probe_rd) begin
            r_rd_data <= r_mem[w_mid];
        end
    end

    assign o_done   = r_done;
    assign o_result = r_result;

endmodule

@@ rtl/core/gcis_ctrl.sv @@
// Controller: sequences clear, load and sample commands over the datapath.
module gcis_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    output logic              o_busy,
    output gcis_pkg::t_dp_cmd o_dp_cmd,
    input  gcis_pkg::t_dp_sts i_sts
);
    import gcis_pkg::*;

    t_state r_state;
    t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands
    always_comb begin
        n_state              = r_state;
        o_dp_cmd             = '0;
        o_dp_cmd.emit_status = STATUS_DONE;
        case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    o_dp_cmd.capture = 1'b1;
                    n_state          = ST_DECODE;
                end
            end
            ST_DECODE: begin
                case (i_sts.mode)
                    MODE_CLEAR: begin
                        o_dp_cmd.clear = 1'b1;
                        o_dp_cmd.emit  = 1'b1;
                        n_state        = ST_IDLE;
                    end
                    MODE_LOAD: begin
                        if (i_sts.grid_full) begin
                            o_dp_cmd.emit        = 1'b1;
                            o_dp_cmd.emit_status = STATUS_FULL;
                            n_state              = ST_IDLE;
                        end else if (!i_sts.weight_pos) begin
                            // skipped cell still takes a raster slot
                            o_dp_cmd.skip = 1'b1;
                            o_dp_cmd.emit = 1'b1;
                            n_state       = ST_IDLE;
                        end else begin
                            o_dp_cmd.div_start = 1'b1;
                            n_state            = ST_DIV;
                        end
                    end
                    MODE_SAMPLE: begin
                        if (i_sts.table_empty) begin
                            o_dp_cmd.emit        = 1'b1;
                            o_dp_cmd.emit_status = STATUS_EMPTY;
                            n_state              = ST_IDLE;
                        end else begin
                            o_dp_cmd.search_init = 1'b1;
                            n_state              = ST_PROBE_RD;
                        end
                    end
                    default: begin
                        // reserved mode: table and config unchanged, result reports done
                        o_dp_cmd.emit = 1'b1;
                        n_state       = ST_IDLE;
                    end
                endcase
            end
            ST_DIV: begin
                if (i_sts.div_done) begin
                    n_state = ST_COMMIT;
                end else begin
                    o_dp_cmd.div_step = 1'b1;
                end
            end
            ST_COMMIT: begin
                o_dp_cmd.commit = 1'b1;
                o_dp_cmd.emit   = 1'b1;
                n_state         = ST_IDLE;
            end
            ST_PROBE_RD: begin
                // when the bounds meet, the midpoint is the answer entry
                o_dp_cmd.probe_rd = 1'b1;
                n_state = i_sts.search_done ? ST_FINAL : ST_PROBE_CMP;
            end
            ST_PROBE_CMP: begin
                o_dp_cmd.probe_upd = 1'b1;
                n_state            = ST_PROBE_RD;
            end
            ST_FINAL: begin
                o_dp_cmd.emit        = 1'b1;
                o_dp_cmd.emit_status = STATUS_OK;
                n_state              = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != ST_IDLE);

endmodule

@@ rtl/core/grid_cdf_inverse_sampler_core.sv @@
// Top level of the grid CDF inverse sampler: controller plus datapath.
//
// Usage: drive i_cmd and pulse i_start while o_busy is low; the command beat
// is taken at that edge. Exactly one result beat follows per command, shown
// on o_result for a single cycle with o_done high; it cannot be held off, so
// the receiver must take it then. Clears, reserved modes, samples of an empty
// table, loads into a full grid and loads of a non-positive weight are
// answered from the decode state. A load with a positive weight runs a
// one-bit-per-cycle raster divider (13 steps) and returns via the commit state.
// A sample does the scaling multiply in the decode state, then runs binary
// search probes (table read, then compare), up to ceil(log2(entries)) probes,
// then the final table read and the result register. A new command can be
// accepted in the cycle its result is shown. The table needs no clearing pass
// after reset.
// Write configuration only while o_busy is low.
module grid_cdf_inverse_sampler_core #(
    parameter int unsigned MAX_CELLS = 4096
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    output logic                           o_busy,
    input  gcis_pkg::t_cmd_beat            i_cmd,
    output logic                           o_done,
    output gcis_pkg::t_result_beat         o_result,
    input  logic                           i_cfg_we,
    input  logic [gcis_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [gcis_pkg::DIM_W-1:0]     i_cfg_data
);
    import gcis_pkg::*;

    t_dp_cmd w_dp_cmd;
    t_dp_sts w_dp_sts;

    gcis_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_start),
        .o_busy   (o_busy),
        .o_dp_cmd (w_dp_cmd),
        .i_sts    (w_dp_sts)
    );

    gcis_datapath #(
        .MAX_CELLS (MAX_CELLS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (i_cmd),
        .i_dp_cmd    (w_dp_cmd),
        .o_sts       (w_dp_sts),
        .o_done      (o_done),
        .o_result    (o_result)
    );

endmodule
